// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Types, constants and the microcode table of the command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcs_pkg;

  localparam int PAGE_BYTES = 256;
  localparam int IDX_W      = $clog2(PAGE_BYTES);
  localparam int STEP_W     = IDX_W + 1;
  localparam int ADDR_W     = 24;
  localparam int LEN_W      = 24;
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] CMD_READ   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_WREN   = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_STATUS = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_PROG   = 8'h0A;
  localparam int STATUS_WEL_BIT = 1;
  localparam int STATUS_WIP_BIT = 0;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_LOAD      = 2'd2,
    OP_XFER_DONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_SEND    = 3'd0,
    K_RELEASE = 3'd1,
    K_READ    = 3'd2,
    K_DONE    = 3'd3,
    K_BUSY    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R_CMD, PH_R_A2, PH_R_A1, PH_R_A0, PH_R_DATA,
    PH_W_WREN, PH_W_S1C, PH_W_S1P, PH_W_CMD, PH_W_A2, PH_W_A1, PH_W_A0,
    PH_W_DATA, PH_W_S2C, PH_W_S2P
  } phase_t;

  // where a result's outgoing byte comes from
  typedef enum logic [3:0] {
    SRC_ZERO, SRC_RDCMD, SRC_WREN, SRC_STATUS, SRC_PROG,
    SRC_A2, SRC_A1, SRC_A0, SRC_PAGE
  } src_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_LEN_NZ, COND_LEN_MORE, COND_RX_WEL, COND_RX_WIP, COND_PAGE_LEFT
  } cond_t;

  typedef enum logic [1:0] {
    STEP_KEEP, STEP_CLR, STEP_INC
  } step_op_t;

  typedef enum logic [1:0] {
    SQ_IDLE, SQ_FETCH, SQ_OUT
  } sq_t;

  // one branch of a control word: up to two results plus state updates
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      kind0;
    src_t       src0;
    kind_t      kind1;
    src_t       src1;
    phase_t     next;
    step_op_t   step_op;
    logic       dec_len;
  } arm_t;

  typedef struct packed {
    cond_t cond;
    arm_t  hit;
    arm_t  miss;
  } ctrl_t;

  function automatic arm_t mk_arm(logic [1:0] cnt, kind_t k0, src_t s0, kind_t k1,
                                  src_t s1, phase_t nx, step_op_t so, logic dec);
    arm_t a;
    a.cnt     = cnt;
    a.kind0   = k0;
    a.src0    = s0;
    a.kind1   = k1;
    a.src1    = s1;
    a.next    = nx;
    a.step_op = so;
    a.dec_len = dec;
    return a;
  endfunction

  function automatic arm_t send1(src_t s, phase_t nx);
    return mk_arm(2'd1, K_SEND, s, K_SEND, SRC_ZERO, nx, STEP_KEEP, 1'b0);
  endfunction

  function automatic ctrl_t plain(arm_t a);
    ctrl_t c;
    c.cond = COND_NONE;
    c.hit  = a;
    c.miss = a;
    return c;
  endfunction

  function automatic ctrl_t branch(cond_t cnd, arm_t h, arm_t m);
    ctrl_t c;
    c.cond = cnd;
    c.hit  = h;
    c.miss = m;
    return c;
  endfunction

  // microcode: one control word per phase, taken on an exchange completion
  function automatic ctrl_t ucode(phase_t p);
    ctrl_t c;
    unique case (p)
      PH_IDLE:   c = plain(mk_arm(2'd0, K_SEND, SRC_ZERO, K_SEND, SRC_ZERO, PH_IDLE,
                                  STEP_KEEP, 1'b0));
      PH_R_CMD:  c = plain(send1(SRC_A2, PH_R_A2));
      PH_R_A2:   c = plain(send1(SRC_A1, PH_R_A1));
      PH_R_A1:   c = plain(send1(SRC_A0, PH_R_A0));
      PH_R_A0:   c = branch(COND_LEN_NZ, send1(SRC_ZERO, PH_R_DATA),
                            mk_arm(2'd1, K_RELEASE, SRC_ZERO, K_SEND, SRC_ZERO,
                                   PH_IDLE, STEP_KEEP, 1'b0));
      PH_R_DATA: c = branch(COND_LEN_MORE,
                            mk_arm(2'd2, K_READ, SRC_ZERO, K_SEND, SRC_ZERO,
                                   PH_R_DATA, STEP_KEEP, 1'b1),
                            mk_arm(2'd2, K_READ, SRC_ZERO, K_RELEASE, SRC_ZERO,
                                   PH_IDLE, STEP_KEEP, 1'b1));
      PH_W_WREN: c = plain(mk_arm(2'd2, K_RELEASE, SRC_ZERO, K_SEND, SRC_STATUS,
                                  PH_W_S1C, STEP_KEEP, 1'b0));
      PH_W_S1C:  c = plain(send1(SRC_ZERO, PH_W_S1P));
      PH_W_S1P:  c = branch(COND_RX_WEL,
                            mk_arm(2'd2, K_RELEASE, SRC_ZERO, K_SEND, SRC_PROG,
                                   PH_W_CMD, STEP_KEEP, 1'b0),
                            send1(SRC_ZERO, PH_W_S1P));
      PH_W_CMD:  c = plain(send1(SRC_A2, PH_W_A2));
      PH_W_A2:   c = plain(send1(SRC_A1, PH_W_A1));
      PH_W_A1:   c = plain(mk_arm(2'd1, K_SEND, SRC_A0, K_SEND, SRC_ZERO, PH_W_A0,
                                  STEP_CLR, 1'b0));
      PH_W_A0, PH_W_DATA:
                 c = branch(COND_PAGE_LEFT,
                            mk_arm(2'd1, K_SEND, SRC_PAGE, K_SEND, SRC_ZERO,
                                   PH_W_DATA, STEP_INC, 1'b0),
                            mk_arm(2'd2, K_RELEASE, SRC_ZERO, K_SEND, SRC_STATUS,
                                   PH_W_S2C, STEP_KEEP, 1'b0));
      PH_W_S2C:  c = plain(send1(SRC_ZERO, PH_W_S2P));
      PH_W_S2P:  c = branch(COND_RX_WIP, send1(SRC_ZERO, PH_W_S2P),
                            mk_arm(2'd2, K_RELEASE, SRC_ZERO, K_DONE, SRC_ZERO,
                                   PH_IDLE, STEP_KEEP, 1'b0));
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] src_byte(src_t s, logic [ADDR_W-1:0] addr,
                                                 logic [BYTE_W-1:0] pbyte);
    logic [BYTE_W-1:0] b;
    unique case (s)
      SRC_ZERO:   b = '0;
      SRC_RDCMD:  b = CMD_READ;
      SRC_WREN:   b = CMD_WREN;
      SRC_STATUS: b = CMD_STATUS;
      SRC_PROG:   b = CMD_PROG;
      SRC_A2:     b = addr[23:16];
      SRC_A1:     b = addr[15:8];
      SRC_A0:     b = addr[7:0];
      SRC_PAGE:   b = pbyte;
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/sfcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/spi_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer
// Steps serial NOR flash read and page program commands, one SPI byte
// exchange per transaction, from a microcode table indexed by phase.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | operation, address, length, page data, rx byte
//  out_    | output    | out_valid / out_ready| kind, send_byte, read_byte, last
//
// Load page byte: written on accept. Start: accept, then its one result.
// Exchange finished: accept, the page buffer read in the FETCH state, then
// each result (1 or 2); with no result it takes only the accept.
// Input is taken only once every result of the previous transaction is gone;
// out_ready low holds the current result. Reset is synchronous and returns
// the sequencer to idle; the page buffer keeps its contents.
`default_nettype none

module spi_flash_command_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [sfcs_pkg::ADDR_W-1:0] in_flash_address,
  input  logic [sfcs_pkg::LEN_W-1:0]  in_read_length,
  input  logic [7:0]                  in_page_index,
  input  logic [7:0]                  in_load_value,
  input  logic [7:0]                  in_received_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_send_byte,
  output logic [7:0]                  out_read_byte,
  output logic                        out_last
);

  import sfcs_pkg::*;

  sq_t                sq_r, sq_nxt;
  logic               slot_r, slot_nxt;
  arm_t               arm_r, arm_nxt;
  logic [BYTE_W-1:0]  rx_r, rx_nxt;
  logic [BYTE_W-1:0]  pbyte_r, pbyte_nxt;
  phase_t             phase_r, phase_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  ctrl_t              uw;
  logic               cond_ok;
  arm_t               sel;
  kind_t              cur_kind;
  src_t               cur_src;
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;

  sfcs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_page_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_page_index)),
    .wdata (in_load_value),
    .raddr (step_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r    <= SQ_IDLE;
      slot_r  <= 1'b0;
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      len_r   <= '0;
      step_r  <= '0;
    end else begin
      sq_r    <= sq_nxt;
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arm_r   <= arm_nxt;
    rx_r    <= rx_nxt;
    pbyte_r <= pbyte_nxt;
  end

  always_comb begin
    uw = ucode(phase_r);
    unique case (uw.cond)
      COND_NONE:      cond_ok = 1'b1;
      COND_LEN_NZ:    cond_ok = (len_r != '0);
      COND_LEN_MORE:  cond_ok = (len_r != LEN_W'(1));
      COND_RX_WEL:    cond_ok = in_received_byte[STATUS_WEL_BIT];
      COND_RX_WIP:    cond_ok = in_received_byte[STATUS_WIP_BIT];
      COND_PAGE_LEFT: cond_ok = (step_r < STEP_W'(PAGE_BYTES));
      default:        cond_ok = 1'b1;
    endcase
    sel = cond_ok ? uw.hit : uw.miss;
  end

  always_comb begin
    sq_nxt    = sq_r;
    slot_nxt  = slot_r;
    arm_nxt   = arm_r;
    rx_nxt    = rx_r;
    pbyte_nxt = pbyte_r;
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    step_nxt  = step_r;
    ram_we    = 1'b0;

    cur_kind  = slot_r ? arm_r.kind1 : arm_r.kind0;
    cur_src   = slot_r ? arm_r.src1 : arm_r.src0;
    in_ready  = (sq_r == SQ_IDLE);
    out_valid = (sq_r == SQ_OUT);
    out_last  = slot_r || (arm_r.cnt == 2'd1);
    out_kind  = cur_kind;
    out_send_byte = (cur_kind == K_SEND) ? src_byte(cur_src, addr_r, pbyte_r) : '0;
    out_read_byte = (cur_kind == K_READ) ? rx_r : '0;

    unique case (sq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          slot_nxt = 1'b0;
          unique case (op_t'(in_operation))
            OP_READ, OP_WRITE: begin
              sq_nxt = SQ_OUT;
              if (phase_r != PH_IDLE) begin
                arm_nxt = mk_arm(2'd1, K_BUSY, SRC_ZERO, K_SEND, SRC_ZERO, phase_r,
                                 STEP_KEEP, 1'b0);
              end else if (op_t'(in_operation) == OP_READ) begin
                arm_nxt   = send1(SRC_RDCMD, PH_R_CMD);
                addr_nxt  = in_flash_address;
                len_nxt   = in_read_length;
                phase_nxt = PH_R_CMD;
              end else begin
                arm_nxt   = send1(SRC_WREN, PH_W_WREN);
                addr_nxt  = in_flash_address;
                step_nxt  = '0;
                phase_nxt = PH_W_WREN;
              end
            end
            OP_LOAD: begin
              ram_we = 1'b1;
            end
            OP_XFER_DONE: begin
              // page buffer read at step_r is launched this cycle
              arm_nxt   = sel;
              rx_nxt    = in_received_byte;
              phase_nxt = sel.next;
              if (sel.dec_len) begin
                len_nxt = len_r - LEN_W'(1);
              end
              unique case (sel.step_op)
                STEP_CLR: step_nxt = '0;
                STEP_INC: step_nxt = step_r + STEP_W'(1);
                default:  step_nxt = step_r;
              endcase
              if (sel.cnt != 2'd0) begin
                sq_nxt = SQ_FETCH;
              end
            end
          endcase
        end
      end
      SQ_FETCH: begin
        pbyte_nxt = ram_rdata;
        sq_nxt    = SQ_OUT;
      end
      SQ_OUT: begin
        if (out_ready) begin
          if (out_last) begin
            sq_nxt = SQ_IDLE;
          end else begin
            slot_nxt = 1'b1;
          end
        end
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/sfcs_checker.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_send_byte,
  input logic [7:0] out_read_byte,
  input logic       out_last
);

  import sfcs_pkg::*;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_kind) && $stable(out_send_byte) && $stable(out_last))
  // no new transaction is taken while results are pending
  `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPL(a_send_zero, clk, rst_n, out_valid && out_kind != K_SEND,
               out_send_byte == 8'd0)
  `ASSERT_IMPL(a_read_zero, clk, rst_n, out_valid && out_kind != K_READ,
               out_read_byte == 8'd0)
  // done and reject always close their transaction
  `ASSERT_IMPL(a_term_last, clk, rst_n, out_valid && (out_kind == K_DONE || out_kind == K_BUSY),
               out_last)

endmodule

bind spi_flash_command_sequencer sfcs_checker u_sfcs_checker (.*);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer testbench
// Drives host requests and SPI exchange completions into the sequencer and
// checks every result against a cycle-free model of the phase machine.
// Requests come from a queue that is filled up front. Reads and page writes
// are built as well-formed command sequences with status polling, busy
// rejections and page loads mixed in. Random stalls are applied on both
// sides of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import sfcs_pkg::*;

  localparam int PLAN  = 0;  // model copy used while building the request queue
  localparam int CHECK = 1;  // model copy advanced on accepted transactions
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 110;

  typedef struct {
    op_t         op;
    logic [23:0] addr;
    logic [23:0] len;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [7:0]  rx;
    bit          hold;  // marker: wait here until all results are back
  } host_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] send_byte;
    logic [7:0] read_byte;
    logic       last;
  } spi_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [ADDR_W-1:0] in_flash_address = '0;
  logic [LEN_W-1:0] in_read_length = '0;
  logic [7:0] in_page_index = '0;
  logic [7:0] in_load_value = '0;
  logic [7:0] in_received_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_send_byte;
  logic [7:0] out_read_byte;
  logic out_last;

  // two copies of the sequencer state
  phase_t      seq_phase [2];
  logic [23:0] seq_addr  [2];
  logic [23:0] seq_left  [2];
  logic [8:0]  seq_step  [2];
  logic [7:0]  seq_page  [2][PAGE_BYTES];

  host_req_t   host_requests[$];
  spi_result_t step_results[$];
  spi_result_t expected_spi_results[$];
  host_req_t   on_bus;

  int n_total = 0;
  int n_live = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_busy = 0;
  int n_read_bytes = 0;
  int n_done = 0;
  int n_page_writes = 0;
  int stall_cycles = 0;

  spi_flash_command_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_flash_address (in_flash_address),
    .in_read_length   (in_read_length),
    .in_page_index    (in_page_index),
    .in_load_value    (in_load_value),
    .in_received_byte (in_received_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_send_byte    (out_send_byte),
    .out_read_byte    (out_read_byte),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  function automatic void put(kind_t k, logic [7:0] sb, logic [7:0] rb);
    spi_result_t e;
    e.kind      = k;
    e.send_byte = sb;
    e.read_byte = rb;
    e.last      = 1'b0;
    step_results.push_back(e);
  endfunction

  // Advance copy s by one request; results land in step_results.
  function automatic void sequence_flash_step(int s, host_req_t r);
    step_results.delete();
    case (r.op)
      OP_READ, OP_WRITE: begin
        if (seq_phase[s] != PH_IDLE) begin
          put(K_BUSY, 8'h00, 8'h00);
        end else if (r.op == OP_READ) begin
          seq_addr[s]  = r.addr;
          seq_left[s]  = r.len;
          seq_phase[s] = PH_R_CMD;
          put(K_SEND, CMD_READ, 8'h00);
        end else begin
          seq_addr[s]  = r.addr;
          seq_step[s]  = '0;
          seq_phase[s] = PH_W_WREN;
          put(K_SEND, CMD_WREN, 8'h00);
        end
      end
      OP_LOAD: seq_page[s][r.idx % PAGE_BYTES] = r.val;
      default: begin
        case (seq_phase[s])
          PH_R_CMD: begin
            put(K_SEND, seq_addr[s][23:16], 8'h00);
            seq_phase[s] = PH_R_A2;
          end
          PH_R_A2: begin
            put(K_SEND, seq_addr[s][15:8], 8'h00);
            seq_phase[s] = PH_R_A1;
          end
          PH_R_A1: begin
            put(K_SEND, seq_addr[s][7:0], 8'h00);
            seq_phase[s] = PH_R_A0;
          end
          PH_R_A0: begin
            if (seq_left[s] != 0) begin
              put(K_SEND, 8'h00, 8'h00);
              seq_phase[s] = PH_R_DATA;
            end else begin
              put(K_RELEASE, 8'h00, 8'h00);
              seq_phase[s] = PH_IDLE;
            end
          end
          PH_R_DATA: begin
            put(K_READ, 8'h00, r.rx);
            seq_left[s] = seq_left[s] - 24'd1;
            if (seq_left[s] != 0) begin
              put(K_SEND, 8'h00, 8'h00);
            end else begin
              put(K_RELEASE, 8'h00, 8'h00);
              seq_phase[s] = PH_IDLE;
            end
          end
          PH_W_WREN: begin
            put(K_RELEASE, 8'h00, 8'h00);
            put(K_SEND, CMD_STATUS, 8'h00);
            seq_phase[s] = PH_W_S1C;
          end
          PH_W_S1C: begin
            put(K_SEND, 8'h00, 8'h00);
            seq_phase[s] = PH_W_S1P;
          end
          PH_W_S1P: begin
            if (r.rx[STATUS_WEL_BIT]) begin
              put(K_RELEASE, 8'h00, 8'h00);
              put(K_SEND, CMD_PROG, 8'h00);
              seq_phase[s] = PH_W_CMD;
            end else begin
              put(K_SEND, 8'h00, 8'h00);
            end
          end
          PH_W_CMD: begin
            put(K_SEND, seq_addr[s][23:16], 8'h00);
            seq_phase[s] = PH_W_A2;
          end
          PH_W_A2: begin
            put(K_SEND, seq_addr[s][15:8], 8'h00);
            seq_phase[s] = PH_W_A1;
          end
          PH_W_A1: begin
            put(K_SEND, seq_addr[s][7:0], 8'h00);
            seq_step[s]  = '0;
            seq_phase[s] = PH_W_A0;
          end
          PH_W_A0, PH_W_DATA: begin
            if (seq_step[s] < PAGE_BYTES) begin
              put(K_SEND, seq_page[s][seq_step[s] % PAGE_BYTES], 8'h00);
              seq_step[s]  = seq_step[s] + 9'd1;
              seq_phase[s] = PH_W_DATA;
            end else begin
              put(K_RELEASE, 8'h00, 8'h00);
              put(K_SEND, CMD_STATUS, 8'h00);
              seq_phase[s] = PH_W_S2C;
            end
          end
          PH_W_S2C: begin
            put(K_SEND, 8'h00, 8'h00);
            seq_phase[s] = PH_W_S2P;
          end
          PH_W_S2P: begin
            if (r.rx[STATUS_WIP_BIT]) begin
              put(K_SEND, 8'h00, 8'h00);
            end else begin
              put(K_RELEASE, 8'h00, 8'h00);
              put(K_DONE, 8'h00, 8'h00);
              seq_phase[s] = PH_IDLE;
            end
          end
          default: ;  // completion while idle is dropped
        endcase
      end
    endcase
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic host_req_t rand_req(op_t op);
    host_req_t r;
    r.op   = op;
    r.addr = 24'($urandom);
    r.len  = 24'($urandom);
    r.idx  = 8'($urandom);
    r.val  = 8'($urandom);
    r.rx   = 8'($urandom);
    r.hold = 1'b0;
    return r;
  endfunction

  task automatic add(host_req_t r);
    if (!(r.op == OP_XFER_DONE && seq_phase[PLAN] == PH_IDLE)) n_live++;
    sequence_flash_step(PLAN, r);
    host_requests.push_back(r);
    n_total++;
  endtask

  task automatic add_hold();
    host_req_t r;
    r = rand_req(OP_LOAD);
    r.hold = 1'b1;
    host_requests.push_back(r);
  endtask

  // Complete the command in flight, steering the status polls and mixing in
  // busy starts and page loads.
  task automatic run_to_idle();
    host_req_t r;
    while (seq_phase[PLAN] != PH_IDLE) begin
      if ($urandom_range(0, 11) == 0) begin
        r = rand_req(op_t'($urandom_range(0, 2)));
      end else begin
        r = rand_req(OP_XFER_DONE);
        if (seq_phase[PLAN] == PH_W_S1P) r.rx[STATUS_WEL_BIT] = ($urandom_range(0, 2) == 0);
        if (seq_phase[PLAN] == PH_W_S2P) r.rx[STATUS_WIP_BIT] = ($urandom_range(0, 3) != 0);
      end
      add(r);
    end
  endtask

  function automatic int idle_pct(bit receiver);
    if (n_accepted * 3 < n_total) return receiver ? 73 : 38;
    if (n_accepted * 3 < 2 * n_total) return receiver ? 38 : 73;
    return 0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sequence_flash_step(CHECK, on_bus);
        foreach (step_results[i]) expected_spi_results.push_back(step_results[i]);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (host_requests.size() != 0 && host_requests[0].hold &&
            expected_spi_results.size() == 0)
          void'(host_requests.pop_front());
        if (host_requests.size() != 0 && !host_requests[0].hold &&
            $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          on_bus = host_requests.pop_front();
          in_valid         <= 1'b1;
          in_operation     <= on_bus.op;
          in_flash_address <= on_bus.addr;
          in_read_length   <= on_bus.len;
          in_page_index    <= on_bus.idx;
          in_load_value    <= on_bus.val;
          in_received_byte <= on_bus.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    spi_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_kind == K_BUSY) n_busy++;
        if (out_kind == K_READ) n_read_bytes++;
        if (out_kind == K_DONE) n_done++;
        if (expected_spi_results.size() == 0) begin
          $error("unexpected result: kind %0d send 0x%0h read 0x%0h last %0b",
                 out_kind, out_send_byte, out_read_byte, out_last);
          n_errors++;
        end else begin
          e = expected_spi_results.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("send_byte", e.send_byte, out_send_byte);
          check_field("read_byte", e.read_byte, out_read_byte);
          check_field("last", e.last, out_last);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    host_req_t r;
    int pick;

    for (int s = 0; s < 2; s++) begin
      seq_phase[s] = PH_IDLE;
      seq_addr[s]  = '0;
      seq_left[s]  = '0;
      seq_step[s]  = '0;
    end

    // fill the whole page buffer so no unwritten byte is ever sent
    for (int i = 0; i < PAGE_BYTES; i++) begin
      r = rand_req(OP_LOAD);
      r.idx = 8'(i);
      if (i == 0) r.val = 8'h00;
      if (i == PAGE_BYTES - 1) r.val = 8'hFF;
      add(r);
    end

    // completion while idle
    r = rand_req(OP_XFER_DONE);
    r.rx = 8'hFF;
    add(r);
    // zero-length read at the top address
    r = rand_req(OP_READ);
    r.addr = 24'hFFFFFF;
    r.len  = '0;
    add(r);
    repeat (4) add(rand_req(OP_XFER_DONE));
    // one-byte read at address zero, with busy starts and a load in flight
    r = rand_req(OP_READ);
    r.addr = '0;
    r.len  = 24'd1;
    add(r);
    r = rand_req(OP_READ);
    r.addr = 24'hFFFFFF;
    r.len  = 24'hFFFFFF;
    add(r);
    add(rand_req(OP_WRITE));
    r = rand_req(OP_LOAD);
    r.idx = 8'hFF;
    r.val = 8'h00;
    add(r);
    repeat (4) add(rand_req(OP_XFER_DONE));
    r = rand_req(OP_XFER_DONE);
    r.rx = 8'hFF;
    add(r);
    // two-byte read
    r = rand_req(OP_READ);
    r.addr = 24'hA5A5A5;
    r.len  = 24'd2;
    add(r);
    repeat (4) add(rand_req(OP_XFER_DONE));
    r = rand_req(OP_XFER_DONE);
    r.rx = 8'h00;
    add(r);
    r = rand_req(OP_XFER_DONE);
    r.rx = 8'h5A;
    add(r);

    // random command sequences
    n_live = 0;
    while (n_live < RANDOM_ITEMS || n_page_writes < 2) begin
      pick = $urandom_range(0, 9);
      if ((n_page_writes == 0 && n_live > 20) ||
          (n_page_writes < 2 && n_live >= RANDOM_ITEMS))
        pick = 0;
      if (pick <= 1) begin
        add_hold();
        r = rand_req(OP_WRITE);
        if (n_page_writes == 0) r.addr = 24'hFFFF00;
        add(r);
        run_to_idle();
        n_page_writes++;
      end else if (pick <= 7) begin
        r = rand_req(OP_READ);
        r.len = ($urandom_range(0, 9) == 0) ? 24'd12 : 24'($urandom_range(0, 4));
        add(r);
        run_to_idle();
      end else begin
        add(rand_req(pick == 8 ? OP_XFER_DONE : OP_LOAD));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (host_requests.size() != 0 || in_valid || expected_spi_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests sent (%0d page writes), %0d results checked:",
             n_total, n_page_writes, n_results);
    $display("%0d bytes read, %0d writes done, %0d busy rejections",
             n_read_bytes, n_done, n_busy);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/sfcs_pkg.sv
src/sfcs_ram.sv
src/spi_flash_command_sequencer.sv
src/sfcs_checker.sv
test/testbench.sv
